@@ rtl/core/lce_pkg.sv @@
package lce_pkg;

	localparam int DefaultLogicCols = 24;
	// The packed row-above field holds this many columns, two bits each.
	localparam int HoutCols = 24;
	localparam int HoutWidth = 2 * HoutCols;
	localparam int CfgDataWidth = 16;
	localparam int CfgIndexWidth = 3;

	// Configuration register indexes.
	localparam logic [CfgIndexWidth-1:0] REG_LUT_TABLE = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_CELL_MODE = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_CARRY_SEL = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_PERTURB_SEL = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_COL_INDEX = 3'd4;
	localparam logic [CfgIndexWidth-1:0] REG_ABOVE_HDIR = 3'd5;
	localparam logic [CfgIndexWidth-1:0] REG_IS_TOP_ROW = 3'd6;

	// Cell modes.
	localparam logic [3:0] CM_LUT4 = 4'd0;
	localparam logic [3:0] CM_LUT_ABOVE = 4'd1;
	localparam logic [3:0] CM_LUT_PAIR = 4'd2;
	localparam logic [3:0] CM_MUX_HD = 4'd3;
	localparam logic [3:0] CM_MUX_DH = 4'd4;
	localparam logic [3:0] CM_MUX_RAW = 4'd5;
	localparam logic [3:0] CM_SHIFT_H = 4'd6;
	localparam logic [3:0] CM_SUM3 = 4'd7;
	localparam logic [3:0] CM_CHAIN = 4'd8;

	// Carry-chain result choices.
	localparam logic [2:0] CRES_V = 3'd0;
	localparam logic [2:0] CRES_V_OR_K = 3'd1;
	localparam logic [2:0] CRES_CARRY = 3'd2;
	localparam logic [2:0] CRES_U_XOR_K = 3'd3;
	localparam logic [2:0] CRES_U_XNOR_K = 3'd4;

	// Perturb codes.
	localparam logic [2:0] PT_BCAST0 = 3'd0;
	localparam logic [2:0] PT_SWAP = 3'd1;
	localparam logic [2:0] PT_PASS = 3'd2;
	localparam logic [2:0] PT_BCAST1 = 3'd3;
	localparam logic [2:0] PT_INVERT = 3'd4;
	localparam logic [2:0] PT_SHIFT = 3'd5;
	localparam logic [2:0] PT_SHIFT_INV = 3'd6;

	// Above-row wire directions.
	localparam logic [1:0] HDIR_LEFT = 2'd0;
	localparam logic [1:0] HDIR_CENTER = 2'd1;
	localparam logic [1:0] HDIR_RIGHT = 2'd2;

	typedef struct packed {
		logic [15:0] lut_table;
		logic [3:0]  cell_mode;
		logic [2:0]  carry_result_sel;
		logic [11:0] perturb_sel;
		logic [4:0]  col_index;
		logic [1:0]  above_hdir;
		logic        is_top_row;
	} cfg_t;

	typedef struct packed {
		logic [1:0]           a_raw;
		logic [1:0]           b_raw;
		logic [1:0]           c_raw;
		logic [1:0]           d_raw;
		logic [1:0]           a_right;
		logic [1:0]           b_right;
		logic [1:0]           c_right;
		logic                 shift_carry_in;
		logic                 carry_in;
		logic [HoutWidth-1:0] above_row_hout;
	} item_t;

	typedef struct packed {
		logic [1:0] z_out;
		logic       carry_out;
		logic       shift_carry_out;
	} res_t;

	function automatic logic [1:0] perturb(input logic [2:0] code, input logic [1:0] v,
		input logic [1:0] right);
		logic [1:0] r;
		case (code)
			PT_BCAST0: r = {v[0], v[0]};
			PT_SWAP: r = {v[0], v[1]};
			PT_PASS: r = v;
			PT_BCAST1: r = {v[1], v[1]};
			PT_INVERT: r = ~v;
			PT_SHIFT: r = {v[0], right[1]};
			PT_SHIFT_INV: r = ~{v[0], right[1]};
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// Reads one column of the row above; columns outside the array read zero.
	function automatic logic [1:0] above_col(input logic [HoutWidth-1:0] hout,
		input logic signed [6:0] col, input logic top, input int cols);
		logic [1:0] r;
		r = 2'd0;
		if (!top && col >= 0 && col < cols && col < HoutCols) begin
			r = hout[{col[4:0], 1'b0} +: 2];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/lce_cfg_regs.sv @@
module lce_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lce_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [lce_pkg::CfgDataWidth-1:0]    cfg_data,
	output lce_pkg::cfg_t                       cfg
);

	lce_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lce_pkg::REG_LUT_TABLE: cfg_q.lut_table <= cfg_data;
				lce_pkg::REG_CELL_MODE: cfg_q.cell_mode <= cfg_data[3:0];
				lce_pkg::REG_CARRY_SEL: cfg_q.carry_result_sel <= cfg_data[2:0];
				lce_pkg::REG_PERTURB_SEL: cfg_q.perturb_sel <= cfg_data[11:0];
				lce_pkg::REG_COL_INDEX: cfg_q.col_index <= cfg_data[4:0];
				lce_pkg::REG_ABOVE_HDIR: cfg_q.above_hdir <= cfg_data[1:0];
				lce_pkg::REG_IS_TOP_ROW: cfg_q.is_top_row <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/lce_eval.sv @@
module lce_eval #(
	parameter int LOGIC_COLS = lce_pkg::DefaultLogicCols
) (
	input  lce_pkg::cfg_t  cfg,
	input  lce_pkg::item_t item,
	output lce_pkg::res_t  res
);

	logic [1:0]        a, b, c, d, ca, cb, cc;
	logic [1:0]        u, v, k, cy, maj, above_here, above_p, above_pm1;
	logic [2:0]        i0, i1;
	logic              cy0, carry_mode;
	logic signed [6:0] col, p;

	assign col = $signed({2'b00, cfg.col_index});

	always_comb begin
		a = lce_pkg::perturb(cfg.perturb_sel[2:0], item.a_raw, item.a_right);
		b = lce_pkg::perturb(cfg.perturb_sel[5:3], item.b_raw, item.b_right);
		c = lce_pkg::perturb(cfg.perturb_sel[8:6], item.c_raw, item.c_right);
		above_here = lce_pkg::above_col(item.above_row_hout, col, cfg.is_top_row, LOGIC_COLS);

		// Shift position for the variable shift mode.
		p = col;
		if ((b | c) != 2'd0) begin
			p = col - $signed({4'd0, b, c[1]});
			if (cfg.above_hdir == lce_pkg::HDIR_CENTER) begin
				p = p + 7'sd4;
			end else if (cfg.above_hdir == lce_pkg::HDIR_RIGHT) begin
				p = p + 7'sd8;
			end
		end
		above_p = lce_pkg::above_col(item.above_row_hout, p, cfg.is_top_row, LOGIC_COLS);
		above_pm1 = lce_pkg::above_col(item.above_row_hout, p - 7'sd1, cfg.is_top_row,
			LOGIC_COLS);

		res.z_out = 2'd0;
		res.carry_out = item.carry_in;
		res.shift_carry_out = item.shift_carry_in;
		carry_mode = 1'b0;
		ca = a;
		cb = b;
		cc = c;
		maj = (a & b) | (a & c) | (b & c);
		d = 2'd0;

		unique case (cfg.cell_mode) inside
			lce_pkg::CM_LUT4, lce_pkg::CM_LUT_ABOVE: begin
				if (cfg.cell_mode == lce_pkg::CM_LUT_ABOVE) begin
					d = above_here;
				end else begin
					d = lce_pkg::perturb(cfg.perturb_sel[11:9], item.d_raw, 2'd0);
				end
				if (!(cfg.cell_mode == lce_pkg::CM_LUT_ABOVE && cfg.is_top_row)) begin
					res.z_out = {cfg.lut_table[{d[1], c[1], b[1], a[1]}],
						cfg.lut_table[{d[0], c[0], b[0], a[0]}]};
				end
			end
			lce_pkg::CM_LUT_PAIR: begin
				res.z_out = {cfg.lut_table[{1'b1, c[1], b[1], a[1]}],
					cfg.lut_table[{1'b0, c[0], b[0], a[0]}]};
			end
			lce_pkg::CM_MUX_HD: begin
				case (c)
					2'd0: res.z_out = a;
					2'd1: res.z_out = b;
					2'd2: res.z_out = above_here;
					default: res.z_out = item.d_raw;
				endcase
			end
			lce_pkg::CM_MUX_DH: begin
				case (c)
					2'd0: res.z_out = a;
					2'd1: res.z_out = b;
					2'd2: res.z_out = item.d_raw;
					default: res.z_out = above_here;
				endcase
			end
			lce_pkg::CM_MUX_RAW: begin
				case (c)
					2'd0: res.z_out = a;
					2'd1: res.z_out = b;
					2'd2: res.z_out = item.b_raw;
					default: res.z_out = 2'd0;
				endcase
			end
			lce_pkg::CM_SHIFT_H: begin
				if (!cfg.is_top_row) begin
					if (c[0]) begin
						// A two-bit window straddling columns p-1 and p.
						if (p >= 0 && p <= LOGIC_COLS) begin
							if (p > 0) begin
								res.z_out[0] = above_pm1[1];
							end
							if (p < LOGIC_COLS) begin
								res.z_out[1] = above_p[0];
							end
						end
					end else begin
						res.z_out = above_p;
					end
				end
			end
			lce_pkg::CM_SUM3: begin
				res.shift_carry_out = maj[1];
				ca = {maj[0], item.shift_carry_in};
				cb = a ^ b ^ c;
				cc = 2'd0;
				carry_mode = 1'b1;
			end
			lce_pkg::CM_CHAIN: begin
				carry_mode = 1'b1;
			end
			default: begin
				res.z_out = 2'd0;
			end
		endcase

		// Two-bit carry chain: U is propagate, V is generate from the table.
		i0 = {cc[0], cb[0], ca[0]};
		i1 = {cc[1], cb[1], ca[1]};
		u = {cfg.lut_table[{1'b1, i1}], cfg.lut_table[{1'b1, i0}]};
		v = {cfg.lut_table[{1'b0, i1}], cfg.lut_table[{1'b0, i0}]};
		cy0 = (~u[0] & v[0]) | (u[0] & item.carry_in);
		k = {cy0, item.carry_in};
		cy = (~u & v) | (u & k);

		if (carry_mode) begin
			res.carry_out = cy[1];
			case (cfg.carry_result_sel)
				lce_pkg::CRES_V: res.z_out = v;
				lce_pkg::CRES_V_OR_K: res.z_out = v | k;
				lce_pkg::CRES_CARRY: res.z_out = cy;
				lce_pkg::CRES_U_XOR_K: res.z_out = u ^ k;
				lce_pkg::CRES_U_XNOR_K: res.z_out = ~(u ^ k);
				default: res.z_out = 2'd0;
			endcase
		end
	end

endmodule

@@ rtl/core/lut_logic_cell_eval.sv @@
// Logic cell evaluator: each accepted item enters the input register, and its cell logic
// result is then loaded into the result register that drives the outputs. The sustained rate
// is one item per clock while out_ready stays high. in_ready drops only when both the input
// and the result registers hold items that cannot advance. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once and are meant to be made while no item is in
// flight; an index outside the register list is ignored.
module lut_logic_cell_eval #(
	parameter int LOGIC_COLS = lce_pkg::DefaultLogicCols
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lce_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [lce_pkg::CfgDataWidth-1:0]   cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         a_raw,
	input  logic [1:0]                         b_raw,
	input  logic [1:0]                         c_raw,
	input  logic [1:0]                         d_raw,
	input  logic [1:0]                         a_right,
	input  logic [1:0]                         b_right,
	input  logic [1:0]                         c_right,
	input  logic                               shift_carry_in,
	input  logic                               carry_in,
	input  logic [lce_pkg::HoutWidth-1:0]      above_row_hout,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         z_out,
	output logic                               carry_out,
	output logic                               shift_carry_out
);

	lce_pkg::cfg_t  cfg;
	lce_pkg::item_t item_s1;
	lce_pkg::res_t  res_comb;
	lce_pkg::res_t  res_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           ready_s1;
	logic           ready_s2;

	lce_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lce_eval #(
		.LOGIC_COLS (LOGIC_COLS)
	) u_eval (
		.cfg  (cfg),
		.item (item_s1),
		.res  (res_comb)
	);

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			item_s1 <= '{a_raw: a_raw, b_raw: b_raw, c_raw: c_raw, d_raw: d_raw,
				a_right: a_right, b_right: b_right, c_right: c_right,
				shift_carry_in: shift_carry_in, carry_in: carry_in,
				above_row_hout: above_row_hout};
		end
		if (ready_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign z_out = res_s2.z_out;
	assign carry_out = res_s2.carry_out;
	assign shift_carry_out = res_s2.shift_carry_out;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int LogicCols = lce_pkg::DefaultLogicCols;
	localparam int RandItems = 1100;
	localparam int CalmItems = 150;

	// Codes that lie outside the defined sets.
	localparam logic [3:0] ModeUnused = 4'd15;
	localparam logic [2:0] CresUnused = 3'd7;
	localparam logic [2:0] PtZero = 3'd7;
	localparam logic [1:0] HdirUnused = 2'd3;

	typedef struct packed {
		lce_pkg::cfg_t  cfg;
		lce_pkg::item_t item;
		logic           known;
		lce_pkg::res_t  res;
	} stim_row_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [lce_pkg::CfgIndexWidth-1:0] cfg_index = '0;
	logic [lce_pkg::CfgDataWidth-1:0]  cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [1:0]                        a_raw = '0;
	logic [1:0]                        b_raw = '0;
	logic [1:0]                        c_raw = '0;
	logic [1:0]                        d_raw = '0;
	logic [1:0]                        a_right = '0;
	logic [1:0]                        b_right = '0;
	logic [1:0]                        c_right = '0;
	logic                              shift_carry_in = 1'b0;
	logic                              carry_in = 1'b0;
	logic [lce_pkg::HoutWidth-1:0]     above_row_hout = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [1:0]                        z_out;
	logic                              carry_out;
	logic                              shift_carry_out;

	lce_pkg::cfg_t cur_cfg = '0;
	lce_pkg::res_t cell_results_q[$];
	stim_row_t     stim_rows[$];
	lce_pkg::res_t head;
	int            errors = 0;
	int            sent = 0;
	int            got = 0;
	int            settings = 0;
	int            stall_left = 0;
	bit            calm = 1'b0;
	bit            tx_bursty = 1'b1;
	bit            rx_bursty = 1'b1;

	lut_logic_cell_eval #(
		.LOGIC_COLS(LogicCols)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.a_raw(a_raw),
		.b_raw(b_raw),
		.c_raw(c_raw),
		.d_raw(d_raw),
		.a_right(a_right),
		.b_right(b_right),
		.c_right(c_right),
		.shift_carry_in(shift_carry_in),
		.carry_in(carry_in),
		.above_row_hout(above_row_hout),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.z_out(z_out),
		.carry_out(carry_out),
		.shift_carry_out(shift_carry_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report(input string what);
		errors++;
		if (errors <= 40) begin
			$display("ERROR %0t: %s", $time, what);
		end
	endtask

	function automatic logic [1:0] perturb_in(input logic [2:0] code, input logic [1:0] v,
		input logic [1:0] nb);
		logic [1:0] shifted;
		shifted = {v[0], nb[1]};
		case (code)
			lce_pkg::PT_BCAST0: return {2{v[0]}};
			lce_pkg::PT_SWAP: return {v[0], v[1]};
			lce_pkg::PT_PASS: return v;
			lce_pkg::PT_BCAST1: return {2{v[1]}};
			lce_pkg::PT_INVERT: return ~v;
			lce_pkg::PT_SHIFT: return shifted;
			lce_pkg::PT_SHIFT_INV: return ~shifted;
			default: return 2'd0;
		endcase
	endfunction

	// Column read of the row above; anything off the array or in the top row is zero.
	function automatic logic [1:0] row_above(input logic [lce_pkg::HoutWidth-1:0] h,
		input int col, input logic top);
		if (top || col < 0 || col >= LogicCols || col >= lce_pkg::HoutCols) begin
			return 2'd0;
		end
		return h[2*col +: 2];
	endfunction

	function automatic lce_pkg::res_t eval_cell(input lce_pkg::cfg_t c,
		input lce_pkg::item_t it);
		logic [1:0]    a, b, cc, d, u, v, k, cy, z, h_lo, h_hi;
		logic          co, sco, chain;
		int            p;
		lce_pkg::res_t r;
		a = perturb_in(c.perturb_sel[2:0], it.a_raw, it.a_right);
		b = perturb_in(c.perturb_sel[5:3], it.b_raw, it.b_right);
		cc = perturb_in(c.perturb_sel[8:6], it.c_raw, it.c_right);
		z = 2'd0;
		co = it.carry_in;
		sco = it.shift_carry_in;
		chain = 1'b0;
		case (c.cell_mode) inside
			lce_pkg::CM_LUT4, lce_pkg::CM_LUT_ABOVE: begin
				if (c.cell_mode == lce_pkg::CM_LUT_ABOVE) begin
					d = row_above(it.above_row_hout, int'(c.col_index), c.is_top_row);
				end else begin
					d = perturb_in(c.perturb_sel[11:9], it.d_raw, 2'd0);
				end
				if (!(c.cell_mode == lce_pkg::CM_LUT_ABOVE && c.is_top_row)) begin
					z[0] = c.lut_table[{d[0], cc[0], b[0], a[0]}];
					z[1] = c.lut_table[{d[1], cc[1], b[1], a[1]}];
				end
			end
			lce_pkg::CM_LUT_PAIR: begin
				z[0] = c.lut_table[{1'b0, cc[0], b[0], a[0]}];
				z[1] = c.lut_table[{1'b1, cc[1], b[1], a[1]}];
			end
			lce_pkg::CM_MUX_HD: begin
				case (cc)
					2'd0: z = a;
					2'd1: z = b;
					2'd2: z = row_above(it.above_row_hout, int'(c.col_index), c.is_top_row);
					default: z = it.d_raw;
				endcase
			end
			lce_pkg::CM_MUX_DH: begin
				case (cc)
					2'd0: z = a;
					2'd1: z = b;
					2'd2: z = it.d_raw;
					default: z = row_above(it.above_row_hout, int'(c.col_index), c.is_top_row);
				endcase
			end
			lce_pkg::CM_MUX_RAW: begin
				case (cc)
					2'd0: z = a;
					2'd1: z = b;
					2'd2: z = it.b_raw;
					default: z = 2'd0;
				endcase
			end
			lce_pkg::CM_SHIFT_H: begin
				if (!c.is_top_row) begin
					p = int'(c.col_index);
					if ((b | cc) != 2'd0) begin
						p = p - int'({b, cc[1]});
						if (c.above_hdir == lce_pkg::HDIR_CENTER) begin
							p = p + 4;
						end else if (c.above_hdir == lce_pkg::HDIR_RIGHT) begin
							p = p + 8;
						end
					end
					// Odd C straddles two columns: high bit of p-1 below, low bit of p above.
					if (cc[0]) begin
						if (p >= 0 && p <= LogicCols) begin
							if (p > 0) begin
								h_lo = row_above(it.above_row_hout, p - 1, 1'b0);
								z[0] = h_lo[1];
							end
							if (p < LogicCols) begin
								h_hi = row_above(it.above_row_hout, p, 1'b0);
								z[1] = h_hi[0];
							end
						end
					end else begin
						z = row_above(it.above_row_hout, p, 1'b0);
					end
				end
			end
			lce_pkg::CM_SUM3: begin
				u = (a & b) | (a & cc) | (b & cc);
				sco = u[1];
				v = a ^ b ^ cc;
				a = {u[0], it.shift_carry_in};
				b = v;
				cc = 2'd0;
				chain = 1'b1;
			end
			lce_pkg::CM_CHAIN: begin
				chain = 1'b1;
			end
			default: begin
			end
		endcase
		if (chain) begin
			u[0] = c.lut_table[{1'b1, cc[0], b[0], a[0]}];
			v[0] = c.lut_table[{1'b0, cc[0], b[0], a[0]}];
			k = {(~u[0] & v[0]) | (u[0] & it.carry_in), it.carry_in};
			u[1] = c.lut_table[{1'b1, cc[1], b[1], a[1]}];
			v[1] = c.lut_table[{1'b0, cc[1], b[1], a[1]}];
			cy = (~u & v) | (u & k);
			co = cy[1];
			case (c.carry_result_sel)
				lce_pkg::CRES_V: z = v;
				lce_pkg::CRES_V_OR_K: z = v | k;
				lce_pkg::CRES_CARRY: z = cy;
				lce_pkg::CRES_U_XOR_K: z = u ^ k;
				lce_pkg::CRES_U_XNOR_K: z = ~(u ^ k);
				default: z = 2'd0;
			endcase
		end
		r.z_out = z;
		r.carry_out = co;
		r.shift_carry_out = sco;
		return r;
	endfunction

	function automatic lce_pkg::cfg_t mk_cfg(input logic [15:0] lut, input logic [3:0] mode,
		input logic [2:0] csel, input logic [11:0] psel, input logic [4:0] col,
		input logic [1:0] hdir, input logic top);
		lce_pkg::cfg_t c;
		c.lut_table = lut;
		c.cell_mode = mode;
		c.carry_result_sel = csel;
		c.perturb_sel = psel;
		c.col_index = col;
		c.above_hdir = hdir;
		c.is_top_row = top;
		return c;
	endfunction

	function automatic logic [11:0] psel4(input logic [2:0] pa, input logic [2:0] pb,
		input logic [2:0] pc, input logic [2:0] pd);
		return {pd, pc, pb, pa};
	endfunction

	function automatic lce_pkg::item_t mk_item(input logic [1:0] a, input logic [1:0] b,
		input logic [1:0] c, input logic [1:0] d, input logic [1:0] ar, input logic [1:0] br,
		input logic [1:0] cr, input logic sci, input logic ci,
		input logic [lce_pkg::HoutWidth-1:0] h);
		lce_pkg::item_t it;
		it.a_raw = a;
		it.b_raw = b;
		it.c_raw = c;
		it.d_raw = d;
		it.a_right = ar;
		it.b_right = br;
		it.c_right = cr;
		it.shift_carry_in = sci;
		it.carry_in = ci;
		it.above_row_hout = h;
		return it;
	endfunction

	function automatic lce_pkg::res_t mk_res(input logic [1:0] z, input logic co,
		input logic sco);
		return {z, co, sco};
	endfunction

	function automatic lce_pkg::item_t rand_item();
		lce_pkg::item_t it;
		int             pick;
		it = lce_pkg::item_t'({$urandom, $urandom});
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			it.above_row_hout = '0;
		end else if (pick == 1) begin
			it.above_row_hout = '1;
		end
		return it;
	endfunction

	task automatic rand_cfg(output lce_pkg::cfg_t c, input bit extreme);
		if (extreme) begin
			c.lut_table = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			case ($urandom_range(0, 3))
				0: c.perturb_sel = '0;
				1: c.perturb_sel = '1;
				2: c.perturb_sel = {4{lce_pkg::PT_SHIFT_INV}};
				default: c.perturb_sel = {4{lce_pkg::PT_SHIFT}};
			endcase
			case ($urandom_range(0, 3))
				0: c.col_index = '0;
				1: c.col_index = 5'(LogicCols - 1);
				2: c.col_index = 5'(LogicCols);
				default: c.col_index = '1;
			endcase
		end else begin
			c.lut_table = 16'($urandom);
			c.perturb_sel = 12'($urandom);
			if ($urandom_range(0, 7) == 0) begin
				c.col_index = 5'($urandom_range(LogicCols, 31));
			end else begin
				c.col_index = 5'($urandom_range(0, LogicCols - 1));
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			c.cell_mode = 4'($urandom_range(int'(lce_pkg::CM_CHAIN) + 1, int'(ModeUnused)));
		end else begin
			c.cell_mode = 4'($urandom_range(int'(lce_pkg::CM_LUT4), int'(lce_pkg::CM_CHAIN)));
		end
		if ($urandom_range(0, 7) == 0) begin
			c.carry_result_sel = 3'($urandom_range(int'(lce_pkg::CRES_U_XNOR_K) + 1,
				int'(CresUnused)));
		end else begin
			c.carry_result_sel = 3'($urandom_range(int'(lce_pkg::CRES_V),
				int'(lce_pkg::CRES_U_XNOR_K)));
		end
		c.above_hdir = 2'($urandom);
		c.is_top_row = ($urandom_range(0, 4) == 0);
	endtask

	task automatic write_reg(input logic [lce_pkg::CfgIndexWidth-1:0] idx,
		input logic [lce_pkg::CfgDataWidth-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_config(input lce_pkg::cfg_t c);
		write_reg(lce_pkg::REG_LUT_TABLE, c.lut_table);
		write_reg(lce_pkg::REG_CELL_MODE, lce_pkg::CfgDataWidth'(c.cell_mode));
		write_reg(lce_pkg::REG_CARRY_SEL, lce_pkg::CfgDataWidth'(c.carry_result_sel));
		write_reg(lce_pkg::REG_PERTURB_SEL, lce_pkg::CfgDataWidth'(c.perturb_sel));
		write_reg(lce_pkg::REG_COL_INDEX, lce_pkg::CfgDataWidth'(c.col_index));
		write_reg(lce_pkg::REG_ABOVE_HDIR, lce_pkg::CfgDataWidth'(c.above_hdir));
		write_reg(lce_pkg::REG_IS_TOP_ROW, lce_pkg::CfgDataWidth'(c.is_top_row));
		cfg_we <= 1'b0;
		cur_cfg = c;
		settings++;
	endtask

	// Stop offering items and let every outstanding result come back.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (cell_results_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Returns at the edge of the transfer with valid still high, so a following item can
	// be presented in the same step without a dip.
	task automatic send_item(input lce_pkg::item_t it, input logic known,
		input lce_pkg::res_t r);
		int gap;
		if (!calm && tx_bursty && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		a_raw <= it.a_raw;
		b_raw <= it.b_raw;
		c_raw <= it.c_raw;
		d_raw <= it.d_raw;
		a_right <= it.a_right;
		b_right <= it.b_right;
		c_right <= it.c_right;
		shift_carry_in <= it.shift_carry_in;
		carry_in <= it.carry_in;
		above_row_hout <= it.above_row_hout;
		do @(posedge clk); while (!in_ready);
		cell_results_q.push_back(known ? r : eval_cell(cur_cfg, it));
		sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got++;
			if (cell_results_q.size() == 0) begin
				report("result transfer with nothing outstanding");
			end else begin
				head = cell_results_q.pop_front();
				if (z_out !== head.z_out) begin
					report($sformatf("z_out %0d, expected %0d", z_out, head.z_out));
				end
				if (carry_out !== head.carry_out) begin
					report($sformatf("carry_out %0d, expected %0d", carry_out, head.carry_out));
				end
				if (shift_carry_out !== head.shift_carry_out) begin
					report($sformatf("shift_carry_out %0d, expected %0d", shift_carry_out,
						head.shift_carry_out));
				end
			end
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!calm && rx_bursty && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 12);
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		lce_pkg::cfg_t                 c;
		lce_pkg::item_t                it;
		int                            rand_sent;
		int                            n;
		int                            ph;
		int                            w;
		logic [11:0]                   pass4;
		logic [lce_pkg::HoutWidth-1:0] hmix;
		pass4 = psel4(lce_pkg::PT_PASS, lce_pkg::PT_PASS, lce_pkg::PT_PASS, lce_pkg::PT_PASS);
		hmix = 48'h9E37_79B9_7F4A;

		// After reset: direct mode with an empty table, carries pass through.
		stim_rows.push_back('{'0, mk_item(0, 0, 0, 0, 0, 0, 0, 1, 1, '0), 1'b1,
			mk_res(0, 1, 1)});
		stim_rows.push_back('{'0, mk_item(3, 3, 3, 3, 3, 3, 3, 0, 1, '1), 1'b1,
			mk_res(0, 1, 0)});
		stim_rows.push_back('{mk_cfg(16'hFFFF, lce_pkg::CM_LUT4, lce_pkg::CRES_V, '0, 0,
			lce_pkg::HDIR_LEFT, 0),
			mk_item(1, 2, 3, 0, 2, 1, 3, 1, 0, hmix), 1'b1, mk_res(3, 0, 1)});
		stim_rows.push_back('{mk_cfg(16'hFFFF, ModeUnused, lce_pkg::CRES_V, '0, 0,
			lce_pkg::HDIR_LEFT, 0),
			mk_item(3, 1, 2, 3, 0, 3, 1, 0, 1, hmix), 1'b1, mk_res(0, 1, 0)});
		// Perturb code seven forces every input to zero, so only table bit 0 is read.
		stim_rows.push_back('{mk_cfg(16'h0001, lce_pkg::CM_LUT4, lce_pkg::CRES_V,
			psel4(PtZero, PtZero, PtZero, PtZero), 0, lce_pkg::HDIR_LEFT, 0),
			mk_item(3, 3, 3, 3, 3, 3, 3, 0, 0, '1), 1'b1, mk_res(3, 0, 0)});
		stim_rows.push_back('{mk_cfg(16'hFFFF, lce_pkg::CM_LUT_ABOVE, lce_pkg::CRES_V, pass4,
			5, lce_pkg::HDIR_LEFT, 1),
			mk_item(2, 1, 3, 0, 1, 1, 1, 1, 1, '1), 1'b1, mk_res(0, 1, 1)});
		stim_rows.push_back('{mk_cfg(16'hA5C3, lce_pkg::CM_LUT_ABOVE, lce_pkg::CRES_V, pass4,
			5, lce_pkg::HDIR_LEFT, 0),
			mk_item(2, 1, 3, 0, 1, 1, 1, 0, 1, hmix), 1'b0, '0});
		stim_rows.push_back('{mk_cfg(16'h6A3C, lce_pkg::CM_LUT_PAIR, lce_pkg::CRES_V, pass4,
			0, lce_pkg::HDIR_LEFT, 0),
			mk_item(1, 3, 2, 1, 0, 0, 0, 1, 0, hmix), 1'b0, '0});
		stim_rows.push_back('{mk_cfg(16'h1234, lce_pkg::CM_MUX_HD, lce_pkg::CRES_V, pass4,
			7, lce_pkg::HDIR_LEFT, 1),
			mk_item(1, 3, 2, 3, 0, 0, 0, 0, 1, '1), 1'b1, mk_res(0, 1, 0)});
		stim_rows.push_back('{mk_cfg(16'h1234, lce_pkg::CM_MUX_HD, lce_pkg::CRES_V, pass4,
			7, lce_pkg::HDIR_LEFT, 0),
			mk_item(2, 3, 3, 1, 0, 0, 0, 1, 0, '1), 1'b1, mk_res(1, 0, 1)});
		stim_rows.push_back('{mk_cfg(16'h1234, lce_pkg::CM_MUX_DH, lce_pkg::CRES_V, pass4,
			5'(LogicCols), lce_pkg::HDIR_LEFT, 0),
			mk_item(1, 2, 3, 2, 0, 0, 0, 0, 0, '1), 1'b1, mk_res(0, 0, 0)});
		stim_rows.push_back('{mk_cfg(16'h1234, lce_pkg::CM_MUX_RAW, lce_pkg::CRES_V, pass4,
			0, lce_pkg::HDIR_LEFT, 0),
			mk_item(1, 2, 3, 2, 0, 0, 0, 1, 1, hmix), 1'b1, mk_res(0, 1, 1)});
		stim_rows.push_back('{mk_cfg(16'h1234, lce_pkg::CM_MUX_RAW, lce_pkg::CRES_V,
			psel4(lce_pkg::PT_PASS, lce_pkg::PT_INVERT, lce_pkg::PT_PASS, lce_pkg::PT_PASS),
			0, lce_pkg::HDIR_LEFT, 0),
			mk_item(3, 1, 2, 0, 0, 0, 0, 0, 1, hmix), 1'b0, '0});
		stim_rows.push_back('{mk_cfg(16'hFFFF, lce_pkg::CM_SHIFT_H, lce_pkg::CRES_V, pass4,
			12, lce_pkg::HDIR_CENTER, 1),
			mk_item(3, 2, 1, 3, 3, 3, 3, 1, 0, '1), 1'b1, mk_res(0, 0, 1)});
		stim_rows.push_back('{mk_cfg(16'h0000, lce_pkg::CM_SHIFT_H, lce_pkg::CRES_V, pass4,
			0, lce_pkg::HDIR_LEFT, 0),
			mk_item(0, 3, 3, 0, 0, 0, 0, 0, 0, '1), 1'b0, '0});
		stim_rows.push_back('{mk_cfg(16'h0000, lce_pkg::CM_SHIFT_H, lce_pkg::CRES_V, pass4,
			20, lce_pkg::HDIR_RIGHT, 0),
			mk_item(0, 2, 1, 0, 0, 0, 0, 1, 1, hmix), 1'b0, '0});
		// Shift lands exactly one past the last column: only the lower half is driven.
		stim_rows.push_back('{mk_cfg(16'h0000, lce_pkg::CM_SHIFT_H, lce_pkg::CRES_V, pass4,
			20, lce_pkg::HDIR_CENTER, 0),
			mk_item(0, 0, 1, 0, 0, 0, 0, 0, 0, '1), 1'b0, '0});
		stim_rows.push_back('{mk_cfg(16'h0000, lce_pkg::CM_SHIFT_H, lce_pkg::CRES_V, pass4,
			10, HdirUnused, 0),
			mk_item(0, 1, 0, 0, 0, 0, 0, 0, 0, hmix), 1'b0, '0});
		stim_rows.push_back('{mk_cfg(16'hE896, lce_pkg::CM_SUM3, lce_pkg::CRES_CARRY, pass4,
			0, lce_pkg::HDIR_LEFT, 0),
			mk_item(3, 3, 1, 0, 0, 0, 0, 1, 1, '0), 1'b0, '0});
		for (int s = int'(lce_pkg::CRES_V); s <= int'(lce_pkg::CRES_U_XNOR_K); s++) begin
			stim_rows.push_back('{mk_cfg(16'h8E17, lce_pkg::CM_CHAIN, 3'(s), pass4, 0,
				lce_pkg::HDIR_LEFT, 0),
				mk_item(2'(s), 2'(3 - s), 2'(s + 1), 0, 0, 0, 0, 1'(s), 1'(s + 1), '0),
				1'b0, '0});
		end
		stim_rows.push_back('{mk_cfg(16'h8E17, lce_pkg::CM_CHAIN, CresUnused, pass4, 0,
			lce_pkg::HDIR_LEFT, 0),
			mk_item(3, 1, 2, 0, 0, 0, 0, 0, 1, '0), 1'b0, '0});
		stim_rows.push_back('{mk_cfg(16'h5AC3, lce_pkg::CM_LUT_PAIR, lce_pkg::CRES_V,
			psel4(lce_pkg::PT_SHIFT, lce_pkg::PT_SHIFT_INV, lce_pkg::PT_SHIFT,
			lce_pkg::PT_SWAP), 0, lce_pkg::HDIR_LEFT, 0),
			mk_item(1, 2, 0, 0, 2, 3, 2, 0, 0, '0), 1'b0, '0});
		stim_rows.push_back('{mk_cfg(16'h3C96, lce_pkg::CM_LUT4, lce_pkg::CRES_V,
			psel4(lce_pkg::PT_BCAST0, lce_pkg::PT_BCAST1, lce_pkg::PT_SWAP,
			lce_pkg::PT_INVERT), 0, lce_pkg::HDIR_LEFT, 0),
			mk_item(1, 2, 1, 2, 0, 0, 0, 1, 0, '0), 1'b0, '0});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r]) begin
			if (stim_rows[r].cfg != cur_cfg) begin
				wait_drain();
				load_config(stim_rows[r].cfg);
			end
			send_item(stim_rows[r].item, stim_rows[r].known, stim_rows[r].res);
		end

		rand_sent = 0;
		ph = 0;
		while (rand_sent < RandItems) begin
			wait_drain();
			rand_cfg(c, ph % 5 == 0);
			load_config(c);
			tx_bursty = ($urandom_range(0, 3) != 0);
			rx_bursty = ($urandom_range(0, 3) != 0);
			n = $urandom_range(20, 60);
			for (int j = 0; j < n && rand_sent < RandItems; j++) begin
				calm = (rand_sent >= RandItems - CalmItems);
				it = rand_item();
				send_item(it, 1'b0, '0);
				rand_sent++;
			end
			ph++;
		end

		in_valid <= 1'b0;
		for (w = 0; w < 1000 && cell_results_q.size() != 0; w++) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
		if (cell_results_q.size() != 0) begin
			report($sformatf("%0d results never arrived", cell_results_q.size()));
		end

		$display("Sent %0d cell items, checked %0d results, over %0d register settings.",
			sent, got, settings);
		$display("Settings drew on every mode and result choice, unused codes included.");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
